// ----- design/kclp_pkg.sv -----
// Shared types and codes for the keyword command line parser.
`default_nettype none
package kclp_pkg;

  typedef logic [7:0] char_t;

  localparam int unsigned WORD_SLOTS = 6;
  localparam logic [2:0] LEN_OVER = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_ARITY   = 2'd3;

  localparam logic [2:0] KIND_SET     = 3'd0;
  localparam logic [2:0] KIND_GET     = 3'd1;
  localparam logic [2:0] KIND_DEL     = 3'd2;
  localparam logic [2:0] KIND_EXISTS  = 3'd3;
  localparam logic [2:0] KIND_PING    = 3'd4;
  localparam logic [2:0] KIND_UNKNOWN = 3'd5;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] kind;
    logic [7:0] total;
  } result_t;

endpackage
`default_nettype wire

// ----- design/kclp_classify.sv -----
// Keyword match, arity check and argument count clamp for one finished line.
`default_nettype none
module kclp_classify #(
  parameter int COUNT_BITS = 8
) (
  input  wire kclp_pkg::char_t    chars [kclp_pkg::WORD_SLOTS],
  input  wire logic [2:0]         word_len,
  input  wire logic [COUNT_BITS-1:0] count,
  output kclp_pkg::result_t       result
);

  logic is_set, is_get, is_del, is_exists, is_ping;
  logic [7:0] total;

  assign is_set = word_len == 3'd3 && chars[0] == "S" && chars[1] == "E"
                  && chars[2] == "T";
  assign is_get = word_len == 3'd3 && chars[0] == "G" && chars[1] == "E"
                  && chars[2] == "T";
  assign is_del = word_len == 3'd3 && chars[0] == "D" && chars[1] == "E"
                  && chars[2] == "L";
  assign is_exists = word_len == 3'd6 && chars[0] == "E" && chars[1] == "X"
                     && chars[2] == "I" && chars[3] == "S" && chars[4] == "T"
                     && chars[5] == "S";
  assign is_ping = word_len == 3'd4 && chars[0] == "P" && chars[1] == "I"
                   && chars[2] == "N" && chars[3] == "G";

  generate
    if (COUNT_BITS > 8) begin : g_clamp
      assign total = (count > COUNT_BITS'(8'hFF)) ? 8'hFF : count[7:0];
    end else begin : g_fit
      assign total = 8'(count);
    end
  endgenerate

  always_comb begin
    result.status = kclp_pkg::ST_OK;
    result.kind   = kclp_pkg::KIND_UNKNOWN;
    result.total  = total;
    if (word_len == 3'd0) begin
      result.status = kclp_pkg::ST_EMPTY;
      result.total  = 8'd0;
    end else if (is_set) begin
      result.kind   = kclp_pkg::KIND_SET;
      result.status = (count == COUNT_BITS'(2)) ? kclp_pkg::ST_OK : kclp_pkg::ST_ARITY;
    end else if (is_get) begin
      result.kind   = kclp_pkg::KIND_GET;
      result.status = (count == COUNT_BITS'(1)) ? kclp_pkg::ST_OK : kclp_pkg::ST_ARITY;
    end else if (is_del) begin
      result.kind   = kclp_pkg::KIND_DEL;
      result.status = (count == COUNT_BITS'(1)) ? kclp_pkg::ST_OK : kclp_pkg::ST_ARITY;
    end else if (is_exists) begin
      result.kind   = kclp_pkg::KIND_EXISTS;
      result.status = (count == COUNT_BITS'(1)) ? kclp_pkg::ST_OK : kclp_pkg::ST_ARITY;
    end else if (is_ping) begin
      result.kind   = kclp_pkg::KIND_PING;
      result.status = (count == COUNT_BITS'(0)) ? kclp_pkg::ST_OK : kclp_pkg::ST_ARITY;
    end else begin
      result.status = kclp_pkg::ST_UNKNOWN;
    end
  end

endmodule
`default_nettype wire

// ----- design/keyword_command_line_parser_core.sv -----
// Top level of the keyword command line parser: input stage, token state, result register.
//
//   channel  | handshake                       | payload
//   ---------+---------------------------------+-----------------------------------------
//   input    | in_valid / in_ready             | data_byte, byte_present, end_of_line
//   output   | out_valid / out_ready           | parse_status, command_kind, argument_total
//
// One byte per cycle unless an end-of-line item waits; the result register loads the result
// when the end-of-line item leaves the input register. The token state updates from the input
// register in one pass; the result register holds a finished line while the next line's bytes
// keep flowing. Only an end-of-line item waits on a full result register.
// Reset (rst, synchronous) clears the token state and both valid flags.
`default_nettype none
module keyword_command_line_parser_core #(
  parameter int COUNT_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       byte_present,
  input  wire logic       end_of_line,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      parse_status,
  output logic [2:0]      command_kind,
  output logic [7:0]      argument_total
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_present;
  logic       s1_eol;
  logic       s1_adv;
  logic       out_free;

  logic                  inside_token, inside_token_next;
  logic [COUNT_BITS-1:0] token_total, token_total_next;
  logic [2:0]            word_len, word_len_next;
  kclp_pkg::char_t       chars [kclp_pkg::WORD_SLOTS];
  kclp_pkg::char_t       chars_next [kclp_pkg::WORD_SLOTS];
  kclp_pkg::char_t       upper;
  logic                  is_space;
  logic                  wr_en;
  logic [2:0]            wr_idx;
  kclp_pkg::result_t     result;

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && (!s1_eol || out_free);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte    <= data_byte;
      s1_present <= byte_present;
      s1_eol     <= end_of_line;
    end
  end

  always_comb begin
    is_space = s1_byte inside {8'h20, [8'h09:8'h0D]};
    upper    = (s1_byte inside {[8'h61:8'h7A]}) ? s1_byte - 8'h20 : s1_byte;

    inside_token_next = inside_token;
    token_total_next  = token_total;
    word_len_next     = word_len;
    wr_en             = 1'b0;
    wr_idx            = word_len;

    if (s1_present) begin
      if (is_space) begin
        inside_token_next = 1'b0;
      end else if (!inside_token) begin
        inside_token_next = 1'b1;
        if (word_len == 3'd0) begin
          wr_en         = 1'b1;
          wr_idx        = 3'd0;
          word_len_next = 3'd1;
        end else if (token_total != COUNT_MAX) begin
          token_total_next = token_total + COUNT_BITS'(1);
        end
      end else if (word_len != 3'd0 && token_total == '0) begin
        if (word_len < 3'(kclp_pkg::WORD_SLOTS)) begin
          wr_en         = 1'b1;
          word_len_next = word_len + 3'd1;
        end else begin
          word_len_next = kclp_pkg::LEN_OVER;
        end
      end
    end

    for (int i = 0; i < kclp_pkg::WORD_SLOTS; i++) begin
      chars_next[i] = (wr_en && wr_idx == 3'(i)) ? upper : chars[i];
    end
  end

  kclp_classify #(
    .COUNT_BITS(COUNT_BITS)
  ) u_classify (
    .chars    (chars_next),
    .word_len (word_len_next),
    .count    (token_total_next),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_token <= 1'b0;
      token_total  <= '0;
      word_len     <= 3'd0;
    end else if (s1_adv) begin
      if (s1_eol) begin
        inside_token <= 1'b0;
        token_total  <= '0;
        word_len     <= 3'd0;
      end else begin
        inside_token <= inside_token_next;
        token_total  <= token_total_next;
        word_len     <= word_len_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int i = 0; i < kclp_pkg::WORD_SLOTS; i++) begin
        chars[i] <= chars_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_eol) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && s1_eol) begin
      parse_status   <= result.status;
      command_kind   <= result.kind;
      argument_total <= result.total;
    end
  end

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_status == kclp_pkg::ST_EMPTY
      |-> command_kind == kclp_pkg::KIND_UNKNOWN && argument_total == 8'd0)
    else $error("empty line result carries a command or a count");

  a_unknown_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && command_kind == kclp_pkg::KIND_UNKNOWN
      |-> parse_status == kclp_pkg::ST_EMPTY || parse_status == kclp_pkg::ST_UNKNOWN)
    else $error("unknown command reported with a success or arity status");

  a_args_after_word: assert property (@(posedge clk) disable iff (rst)
    word_len == 3'd0 |-> token_total == '0)
    else $error("argument counted before the command word");

  a_eol_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_eol && out_valid && !out_ready |=> s1_valid && s1_eol)
    else $error("end-of-line item dropped while result register was full");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with an empty input register");

endmodule
`default_nettype wire
